// ----- hw/rtl/cfr_pkg.sv -----
// cfr_pkg: shared types, constants and the byte classifier for char_frequency_rank
// used by cfr_cell, char_frequency_rank and cfr_checker; depends on nothing
package cfr_pkg;

   localparam int NUM_BINS        = 28;
   localparam int NUM_LETTERS     = 26;
   localparam int BIN_WIDTH       = 5;
   localparam int OUT_COUNT_WIDTH = 24;
   localparam int STEP_WIDTH      = 5;

   localparam logic [BIN_WIDTH-1:0] BIN_SPACE   = 5'd26;
   localparam logic [BIN_WIDTH-1:0] BIN_NEWLINE = 5'd27;
   localparam logic [BIN_WIDTH-1:0] BIN_LAST    = 5'd27;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   localparam logic OP_COUNT  = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // control broadcast along the cell row
   typedef struct packed {
      logic                 count_en;
      logic [BIN_WIDTH-1:0] hit_bin;
      logic                 load;
      logic                 sort_en;
      logic                 phase;
      logic                 shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic                 hit;
      logic [BIN_WIDTH-1:0] bin;
   } byte_class_type;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type c;
      logic [7:0]     d;
      c.hit = 1'b0;
      c.bin = '0;
      d     = '0;
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         d     = b - CHAR_UPPER_A;
         c.hit = 1'b1;
         c.bin = d[BIN_WIDTH-1:0];
      end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
         d     = b - CHAR_LOWER_A;
         c.hit = 1'b1;
         c.bin = d[BIN_WIDTH-1:0];
      end else if (b == CHAR_SPACE) begin
         c.hit = 1'b1;
         c.bin = BIN_SPACE;
      end else if (b == CHAR_NEWLINE) begin
         c.hit = 1'b1;
         c.bin = BIN_NEWLINE;
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/cfr_cell.sv -----
// cfr_cell: one bin of the histogram plus one slot of the sorting row
// depends on cfr_pkg
module cfr_cell
   import cfr_pkg::*;
#(
   parameter int COUNT_WIDTH = 24,
   parameter int BIN_INDEX   = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_ctrl_type          ctrl,
   input  logic [COUNT_WIDTH-1:0] left_val,
   input  logic [BIN_WIDTH-1:0]   left_label,
   input  logic [COUNT_WIDTH-1:0] right_val,
   input  logic [BIN_WIDTH-1:0]   right_label,
   output logic [COUNT_WIDTH-1:0] val,
   output logic [BIN_WIDTH-1:0]   label
);

   localparam logic                 MY_PARITY = 1'(BIN_INDEX % 2);
   localparam bit                   HAS_LEFT  = (BIN_INDEX > 0);
   localparam bit                   HAS_RIGHT = (BIN_INDEX < NUM_BINS - 1);
   localparam logic [BIN_WIDTH-1:0] MY_BIN    = BIN_WIDTH'(BIN_INDEX);

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] val_ff, val_in;
   logic [BIN_WIDTH-1:0]   label_ff, label_in;
   logic                   as_left, as_right;

   assign as_left  = HAS_RIGHT && (ctrl.phase == MY_PARITY);
   assign as_right = HAS_LEFT && (ctrl.phase != MY_PARITY);

   always_comb begin
      count_in = count_ff;
      val_in   = val_ff;
      label_in = label_ff;
      if (ctrl.count_en && ctrl.hit_bin == MY_BIN && count_ff != '1) begin
         count_in = count_ff + 1'b1;
      end
      if (ctrl.load) begin
         count_in = '0;
         val_in   = count_ff;
         label_in = MY_BIN;
      end else if (ctrl.sort_en) begin
         // strict compare keeps equal counts in bin order
         if (as_left && val_ff < right_val) begin
            val_in   = right_val;
            label_in = right_label;
         end else if (as_right && left_val < val_ff) begin
            val_in   = left_val;
            label_in = left_label;
         end
      end else if (ctrl.shift) begin
         val_in   = right_val;
         label_in = right_label;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         label_ff <= MY_BIN;
      end else begin
         count_ff <= count_in;
         label_ff <= label_in;
      end
      val_ff <= val_in;
   end

   assign val   = val_ff;
   assign label = label_ff;

endmodule

// ----- hw/rtl/char_frequency_rank.sv -----
// char_frequency_rank: top level, letter/space/newline histogram with ranked report
// depends on cfr_pkg and cfr_cell
//
// A count transaction (operation 0) takes one text byte per cycle while req_ready
// is high and adds it to one of 28 saturating counters; letters fold case into
// bins 0..25, space is bin 26, newline bin 27, any other byte is dropped. A report
// transaction (operation 1) copies every counter into a row of 28 sort slots and
// clears the counters in the same cycle, then runs odd-even transposition phases
// between neighbouring cells, then streams 28 result transactions (bin, count,
// rank_last) from the head of the row at up to one per cycle as rsp_ready allows.
// Counts are ranked descending and equal counts keep ascending bin order. A report
// therefore holds req_ready low through the sort and the 28 result transactions;
// the sort length is set by the number of cells in the row. Only the low 24 bits
// of a counter are reported when COUNT_WIDTH is wider.
module char_frequency_rank
   import cfr_pkg::*;
#(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_operation,
   input  logic [7:0]                 req_text_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [BIN_WIDTH-1:0]       rsp_bin,
   output logic [OUT_COUNT_WIDTH-1:0] rsp_count,
   output logic                       rsp_rank_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SORT,
      ST_DRAIN
   } state_type;

   state_type               state_ff, state_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;   // sort phase or result index

   logic                    req_fire, rsp_fire;
   byte_class_type          cls;
   cell_ctrl_type           ctrl;

   logic [COUNT_WIDTH-1:0]  vals   [NUM_BINS];
   logic [BIN_WIDTH-1:0]    labels [NUM_BINS];

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign cls       = classify(req_text_byte);

   // control broadcast to every cell
   always_comb begin
      ctrl.count_en = req_fire && (req_operation == OP_COUNT) && cls.hit;
      ctrl.hit_bin  = cls.bin;
      ctrl.load     = req_fire && (req_operation == OP_REPORT);
      ctrl.sort_en  = (state_ff == ST_SORT);
      ctrl.phase    = step_ff[0];
      ctrl.shift    = rsp_fire;
   end

   // sequencer: idle, sort phases, result drain
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.load) begin
               state_in = ST_SORT;
               step_in  = '0;
            end
         end
         ST_SORT: begin
            if (step_ff == STEP_WIDTH'(NUM_BINS - 1)) begin
               state_in = ST_DRAIN;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (rsp_fire) begin
               if (step_ff == STEP_WIDTH'(NUM_BINS - 1)) begin
                  state_in = ST_IDLE;
                  step_in  = '0;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // row of cells, each talking to its neighbours only
   for (genvar i = 0; i < NUM_BINS; i++) begin : g_cell
      logic [COUNT_WIDTH-1:0] lv, rv;
      logic [BIN_WIDTH-1:0]   ll, rl;
      if (i > 0) begin : g_left
         assign lv = vals[i-1];
         assign ll = labels[i-1];
      end else begin : g_edge_left
         assign lv = '0;
         assign ll = '0;
      end
      if (i < NUM_BINS - 1) begin : g_right
         assign rv = vals[i+1];
         assign rl = labels[i+1];
      end else begin : g_edge_right
         assign rv = '0;
         assign rl = '0;
      end
      cfr_cell #(
         .COUNT_WIDTH (COUNT_WIDTH),
         .BIN_INDEX   (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_val    (lv),
         .left_label  (ll),
         .right_val   (rv),
         .right_label (rl),
         .val         (vals[i]),
         .label       (labels[i])
      );
   end

   // results come from the head of the row, which shifts on each accept
   assign rsp_bin       = labels[0];
   assign rsp_count     = OUT_COUNT_WIDTH'(vals[0]);
   assign rsp_rank_last = (step_ff == STEP_WIDTH'(NUM_BINS - 1));

endmodule

// ----- hw/rtl/cfr_checker.sv -----
// cfr_checker: port-level assertions for char_frequency_rank, with its bind
// depends on cfr_pkg and char_frequency_rank
module cfr_checker
   import cfr_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_operation,
   input logic [7:0]                 req_text_byte,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [BIN_WIDTH-1:0]       rsp_bin,
   input logic [OUT_COUNT_WIDTH-1:0] rsp_count,
   input logic                       rsp_rank_last
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin) && $stable(rsp_count)
         && $stable(rsp_rank_last))
      else $error("stalled result changed");

   // no new transaction is taken while a report drains
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted during report");

   // a report transaction closes the input side for the sort
   a_report_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_REPORT |=> !req_ready && !rsp_valid)
      else $error("report did not start sorting");

   // the last ranked result ends the report
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_rank_last |=> !rsp_valid && req_ready)
      else $error("report did not end after last result");

   // only real bins are reported
   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bin <= BIN_LAST)
      else $error("bin out of range");

endmodule

bind char_frequency_rank cfr_checker u_cfr_checker (.*);
